[src/brf_pkg.sv]
// ----------------------------------------------------------------------------
// brf_pkg
// shared types, constants and register indexes of the button edge/repeat filter
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int CHANNELS = 4;
    localparam int CH_W     = 2;
    localparam int MASK_W   = 16;
    localparam int CNT_W    = 8;
    localparam int MODE_W   = 2;
    localparam int LATCH_W  = 2;
    localparam int STAT_W   = 2;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MODE     = 2'd2;

    localparam logic [CNT_W-1:0]  RESET_DELAY  = 8'd45;
    localparam logic [CNT_W-1:0]  RESET_PERIOD = 8'd8;

    // link status codes
    localparam logic [STAT_W-1:0] STAT_GOOD     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_XFER_ERR = 2'd1;

    // axis filter modes
    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VERT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HORIZ = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd3;

    // axis latch values
    localparam logic [LATCH_W-1:0] LATCH_NONE  = 2'd0;
    localparam logic [LATCH_W-1:0] LATCH_VERT  = 2'd1;
    localparam logic [LATCH_W-1:0] LATCH_HORIZ = 2'd2;

    localparam logic [MASK_W-1:0] DIR_HORIZ = 16'h0003;
    localparam logic [MASK_W-1:0] DIR_VERT  = 16'h000C;

    typedef struct packed {
        logic [CNT_W-1:0]  repeat_delay;
        logic [CNT_W-1:0]  repeat_period;
        logic [MODE_W-1:0] axis_mode;
    } t_cfg;

    typedef struct packed {
        logic [MASK_W-1:0]  held;
        logic [CNT_W-1:0]   cnt;
        logic [LATCH_W-1:0] latch;
    } t_chan_state;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [STAT_W-1:0] status;
        logic [MASK_W-1:0] raw;
    } t_item;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic              present;
        logic [MASK_W-1:0] held;
        logic [MASK_W-1:0] pressed;
        logic [MASK_W-1:0] released;
        logic [MASK_W-1:0] rep;
    } t_result;

endpackage

[src/brf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// brf_cfg_regs
// configuration register bank: repeat delay, repeat period, axis filter mode
// ----------------------------------------------------------------------------
module brf_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [brf_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [brf_pkg::CFG_W-1:0]      i_cfg_wdata,
    output brf_pkg::t_cfg                  o_cfg
);

    brf_pkg::t_cfg r_cfg;
    brf_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                brf_pkg::CFG_REPEAT_DELAY:  n_cfg.repeat_delay  = i_cfg_wdata;
                brf_pkg::CFG_REPEAT_PERIOD: n_cfg.repeat_period = i_cfg_wdata;
                brf_pkg::CFG_AXIS_MODE:
                    n_cfg.axis_mode = i_cfg_wdata[brf_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_delay  <= brf_pkg::RESET_DELAY;
            r_cfg.repeat_period <= brf_pkg::RESET_PERIOD;
            r_cfg.axis_mode     <= brf_pkg::MODE_OFF;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/brf_state.sv]
// ----------------------------------------------------------------------------
// brf_state
// per-channel state file: held mask, repeat counter, axis latch
// ----------------------------------------------------------------------------
module brf_state (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [brf_pkg::CH_IDX_W-1:0]  i_rd_ch,
    output brf_pkg::t_chan_state          o_rd_state,
    input  logic                          i_wr_en,
    input  logic [brf_pkg::CH_IDX_W-1:0]  i_wr_ch,
    input  brf_pkg::t_chan_state          i_wr_state
);

    brf_pkg::t_chan_state r_state [brf_pkg::CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < brf_pkg::CHANNELS; i++) begin
                r_state[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_state[i_wr_ch] <= i_wr_state;
        end
    end

    assign o_rd_state = r_state[i_rd_ch];

endmodule

[src/brf_calc.sv]
// ----------------------------------------------------------------------------
// brf_calc
// one-sample update: axis filter, edge detect and auto-repeat counter
// ----------------------------------------------------------------------------
module brf_calc (
    input  brf_pkg::t_cfg         i_cfg,
    input  brf_pkg::t_item        i_item,
    input  brf_pkg::t_chan_state  i_state,
    output logic                  o_wr_en,
    output brf_pkg::t_chan_state  o_state,
    output brf_pkg::t_result      o_result
);

    logic                           in_range;
    logic                           vert;
    logic                           horiz;
    logic [brf_pkg::MASK_W-1:0]     filt;
    logic [brf_pkg::LATCH_W-1:0]    latch_nx;
    logic [brf_pkg::MASK_W-1:0]     now;
    logic [brf_pkg::MASK_W-1:0]     diff;
    logic [brf_pkg::CNT_W-1:0]      cnt_dec;
    logic                           present;

    assign in_range = (int'(i_item.channel) < brf_pkg::CHANNELS);
    assign vert     = |(i_item.raw & brf_pkg::DIR_VERT);
    assign horiz    = |(i_item.raw & brf_pkg::DIR_HORIZ);

    // direction-pad filter, latch only moves in first-pressed mode
    always_comb begin
        filt     = i_item.raw;
        latch_nx = i_state.latch;
        case (i_cfg.axis_mode)
            brf_pkg::MODE_VERT: begin
                if (vert) filt = i_item.raw & ~brf_pkg::DIR_HORIZ;
            end
            brf_pkg::MODE_HORIZ: begin
                if (horiz) filt = i_item.raw & ~brf_pkg::DIR_VERT;
            end
            brf_pkg::MODE_FIRST: begin
                if (vert && horiz) begin
                    if (i_state.latch == brf_pkg::LATCH_VERT) begin
                        filt = i_item.raw & ~brf_pkg::DIR_HORIZ;
                    end else begin
                        filt = i_item.raw & ~brf_pkg::DIR_VERT;
                    end
                end else if (vert) begin
                    latch_nx = brf_pkg::LATCH_VERT;
                end else if (horiz) begin
                    latch_nx = brf_pkg::LATCH_HORIZ;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        case (i_item.status)
            brf_pkg::STAT_GOOD: begin
                now     = filt;
                present = 1'b1;
            end
            brf_pkg::STAT_XFER_ERR: begin
                now     = i_state.held;
                present = 1'b1;
            end
            default: begin
                now     = '0;
                present = 1'b0;
            end
        endcase
    end

    assign diff    = i_state.held ^ now;
    assign cnt_dec = i_state.cnt - 1'b1;

    always_comb begin
        o_state.held  = now;
        o_state.latch = (i_item.status == brf_pkg::STAT_GOOD) ? latch_nx : i_state.latch;
        o_result.channel  = i_item.channel;
        o_result.present  = present;
        o_result.held     = now;
        o_result.pressed  = now & diff;
        o_result.released = i_state.held & diff;
        if (diff != '0) begin
            o_result.rep = now & diff;
            o_state.cnt  = i_cfg.repeat_delay;
        end else if (cnt_dec != '0) begin
            o_result.rep = '0;
            o_state.cnt  = cnt_dec;
        end else begin
            o_result.rep = now;
            o_state.cnt  = i_cfg.repeat_period;
        end
        // channel with no state: echo it, report nothing
        if (!in_range) begin
            o_result.present  = 1'b0;
            o_result.held     = '0;
            o_result.pressed  = '0;
            o_result.released = '0;
            o_result.rep      = '0;
        end
    end

    assign o_wr_en = in_range;

endmodule

[src/button_edge_repeat_filter_unit.sv]
// ----------------------------------------------------------------------------
// button_edge_repeat_filter_unit
// controller button tracker with press/release edges and key auto-repeat
// ----------------------------------------------------------------------------
// Each input transfer carries one controller sample (channel, link status,
// 16-bit raw button mask) and produces exactly one result transfer, in order.
// The unit holds two register stages: an input register and a result
// register, with the per-channel update done combinationally between them.
// A sample is accepted every cycle as long as the result side keeps taking
// results, so sustained rate is one sample per clock; each sample passes
// the input register, then the result register. The per-channel state (held
// mask, 8-bit repeat counter, axis latch) is read and written in the same
// cycle the result is registered, so back-to-back samples on one channel see
// each other's updates with no stall. Configuration writes take effect on the
// next clock and should only be issued while no sample is in flight.
// ----------------------------------------------------------------------------
module button_edge_repeat_filter_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [brf_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [brf_pkg::CFG_W-1:0]         i_cfg_wdata,
    // sample input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [brf_pkg::CH_W-1:0]          i_channel,
    input  logic [brf_pkg::STAT_W-1:0]        i_link_status,
    input  logic [brf_pkg::MASK_W-1:0]        i_raw_buttons,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [brf_pkg::CH_W-1:0]          o_out_channel,
    output logic                              o_present,
    output logic [brf_pkg::MASK_W-1:0]        o_held_mask,
    output logic [brf_pkg::MASK_W-1:0]        o_pressed_mask,
    output logic [brf_pkg::MASK_W-1:0]        o_released_mask,
    output logic [brf_pkg::MASK_W-1:0]        o_repeat_mask
);

    brf_pkg::t_cfg         cfg;
    brf_pkg::t_chan_state  rd_state;
    brf_pkg::t_chan_state  wr_state;
    brf_pkg::t_result      calc_result;
    logic                  calc_wr_en;
    logic                  advance;
    logic                  in_xfer;

    logic                  r_in_valid;
    brf_pkg::t_item        r_item;
    logic                  r_out_valid;
    brf_pkg::t_result      r_result;

    brf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // result register frees up when empty or when its transfer completes
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.channel <= i_channel;
            r_item.status  <= i_link_status;
            r_item.raw     <= i_raw_buttons;
        end
    end

    // state read for the item in the input register, written as it moves on
    brf_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_ch    (r_item.channel[brf_pkg::CH_IDX_W-1:0]),
        .o_rd_state (rd_state),
        .i_wr_en    (advance && calc_wr_en),
        .i_wr_ch    (r_item.channel[brf_pkg::CH_IDX_W-1:0]),
        .i_wr_state (wr_state)
    );

    brf_calc u_calc (
        .i_cfg    (cfg),
        .i_item   (r_item),
        .i_state  (rd_state),
        .o_wr_en  (calc_wr_en),
        .o_state  (wr_state),
        .o_result (calc_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= calc_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_channel   = r_result.channel;
    assign o_present       = r_result.present;
    assign o_held_mask     = r_result.held;
    assign o_pressed_mask  = r_result.pressed;
    assign o_released_mask = r_result.released;
    assign o_repeat_mask   = r_result.rep;

    // a button is never both pressed and released in one sample
    a_edges_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_pressed_mask & o_released_mask) == '0))
        else $error("pressed and released masks overlap");

    // repeat only reports buttons that are held
    a_repeat_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_repeat_mask & ~o_held_mask) == '0))
        else $error("repeat mask outside held mask");

    // an absent controller holds nothing and presses nothing
    a_absent_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_present) |-> (o_held_mask == '0 && o_pressed_mask == '0))
        else $error("absent controller reports held buttons");

    // a stalled result is not overwritten by the next sample
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_result)))
        else $error("stalled result changed");

endmodule
